FILE: hw/rtl/fee_pkg.sv
package fee_pkg;

    localparam int ADDR_W   = 11;
    localparam int DATA_W   = 8;
    localparam int ACTION_W = 3;
    localparam int ADDR_MAX = (1 << ADDR_W) - 1;

    localparam int BYTES_EMULATED_DEF = 2048;
    localparam int COPY_COUNT_DEF     = 8;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNCHANGED = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_IN_PLACE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_NEW_COPY  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ERASED    = 3'd4;

    // Flags from the shared byte compare unit.
    typedef struct packed {
        logic a_erased;
        logic b_erased;
        logic equal;
        logic clear_only;
    } cmp_flags_t;

    // Number of restoring steps that bring any address below the byte count.
    function automatic int mod_steps(input int bytes);
        int steps;
        steps = 0;
        while ((bytes << steps) <= ADDR_MAX) begin
            steps++;
        end
        return steps;
    endfunction

endpackage

FILE: hw/rtl/fee_if.sv
interface fee_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [fee_pkg::ADDR_W-1:0]   address;
    logic [fee_pkg::DATA_W-1:0]   write_value;

    modport source (output valid, req_type, address, write_value, input ready);
    modport sink (input valid, req_type, address, write_value, output ready);
endinterface

interface fee_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fee_pkg::DATA_W-1:0]   read_data;
    logic [fee_pkg::ACTION_W-1:0] action;

    modport source (output valid, read_data, action, input ready);
    modport sink (input valid, read_data, action, output ready);
endinterface

FILE: hw/rtl/fee_ram.sv
module fee_ram #(
    parameter int WIDTH = fee_pkg::DATA_W,
    parameter int DEPTH = fee_pkg::BYTES_EMULATED_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fee_byte_unit.sv
module fee_byte_unit (
    input  logic [fee_pkg::DATA_W-1:0] a,
    input  logic [fee_pkg::DATA_W-1:0] b,
    output fee_pkg::cmp_flags_t        flags
);

    // Operand a is the stored byte, operand b the new value. Programming can
    // only clear bits, so b fits over a when it sets no bit that a lacks.
    always_comb
    begin
        flags.a_erased   = (a == fee_pkg::ERASED_BYTE);
        flags.b_erased   = (b == fee_pkg::ERASED_BYTE);
        flags.equal      = (a == b);
        flags.clear_only = ((~a & b) == '0);
    end

endmodule

FILE: hw/rtl/fee_addr_mod.sv
module fee_addr_mod #(
    parameter int BYTES_EMULATED = fee_pkg::BYTES_EMULATED_DEF,
    localparam int AW            = $clog2(BYTES_EMULATED)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fee_pkg::ADDR_W-1:0] address,
    output logic                       done,
    output logic [AW-1:0]              rem
);

    localparam int STEPS = fee_pkg::mod_steps(BYTES_EMULATED);
    localparam int CNT_W = (STEPS > 0) ? $clog2(STEPS + 1) : 1;

    logic [fee_pkg::ADDR_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [fee_pkg::ADDR_W-1:0] divisor;

    // One restoring subtract per cycle, largest shifted divisor first.
    always_comb
    begin
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        divisor   = fee_pkg::ADDR_W'(BYTES_EMULATED) << (cnt_reg - CNT_W'(1));
        done      = busy_reg && (cnt_reg == '0);
        if (start)
        begin
            r_next    = address;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (r_reg >= divisor)
                begin
                    r_next = r_reg - divisor;
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign rem = AW'(r_reg);

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r_reg < BYTES_EMULATED))
        else $error("address remainder not below the byte count");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("modulo unit did not start");

endmodule

FILE: hw/rtl/flash_eeprom_emulation_unit.sv
// Byte EEPROM emulated on one modelled flash page that holds COPY_COUNT
// copies of a BYTES_EMULATED byte address space. Each beat on req is a read
// or a write of one byte; each produces exactly one beat on rsp, in order,
// carrying the cached byte for a read (zero for a write) and an action code:
// 0 read, 1 unchanged, 2 programmed in place, 3 new copy, 4 page erased and
// rewritten. Addresses are taken modulo BYTES_EMULATED. The block works on
// one item at a time and holds req.ready low until the item is finished and
// its result is in the output register. A read reduces the address, reads
// the cache and loads the result into the output register. The address
// reduction needs no restoring step when BYTES_EMULATED is 2048 or more and
// otherwise does one restoring step per cycle. A write reduces the address,
// searches the copies downward for the newest programmed copy, then searches
// upward for an erased copy when one is needed, before its result is
// loaded. A page erase sweeps all COPY_COUNT * BYTES_EMULATED bytes of the
// page (16384 at the default sizes) through the single flash write port,
// with copy zero refilled from the cache in the same sweep. After reset the
// block runs a clearing pass over the same bytes that sets flash and cache
// to 0xFF, and accepts no beat until it is done.
module flash_eeprom_emulation_unit #(
    parameter int BYTES_EMULATED = fee_pkg::BYTES_EMULATED_DEF,
    parameter int COPY_COUNT     = fee_pkg::COPY_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fee_req_if.sink   req,
    fee_rsp_if.source rsp
);

    localparam int AW          = $clog2(BYTES_EMULATED);
    localparam int CW          = $clog2(COPY_COUNT);
    localparam int FA_W        = CW + AW;
    localparam int FLASH_DEPTH = COPY_COUNT << AW;

    localparam logic [AW-1:0] LAST_ADDR = AW'(BYTES_EMULATED - 1);
    localparam logic [CW-1:0] LAST_COPY = CW'(COPY_COUNT - 1);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b0_0000_0001,
        S_IDLE    = 9'b0_0000_0010,
        S_MOD     = 9'b0_0000_0100,
        S_RD_WAIT = 9'b0_0000_1000,
        S_DN_CHK  = 9'b0_0001_0000,
        S_DECIDE  = 9'b0_0010_0000,
        S_UP_CHK  = 9'b0_0100_0000,
        S_ERASE   = 9'b0_1000_0000,
        S_DONE    = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Item being worked on.
    logic                         kind_reg, kind_next;
    logic [fee_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [AW-1:0]                addr_reg, addr_next;

    // Copy search: index of the copy whose read is in flight, and the newest
    // programmed copy found with its contents.
    logic [CW-1:0]                copy_reg, copy_next;
    logic [CW-1:0]                where_reg, where_next;
    logic [fee_pkg::DATA_W-1:0]   cur_reg, cur_next;

    // Sweep counters shared by the clearing pass and the page erase.
    logic [AW-1:0]                sw_addr_reg, sw_addr_next;
    logic [CW-1:0]                sw_copy_reg, sw_copy_next;
    logic                         sw_last;

    // Erase write stage: the cache read for copy zero lands in the cycle after
    // it is issued, so each erase write goes out in the following cycle.
    logic                         pw_valid_reg, pw_valid_next;
    logic [FA_W-1:0]              pw_addr_reg, pw_addr_next;
    logic                         pw_from_cache_reg, pw_from_cache_next;

    // Finished result and the output register.
    logic [fee_pkg::DATA_W-1:0]   res_data_reg, res_data_next;
    logic [fee_pkg::ACTION_W-1:0] res_action_reg, res_action_next;
    logic                         out_valid_reg, out_valid_next;
    logic [fee_pkg::DATA_W-1:0]   out_data_reg, out_data_next;
    logic [fee_pkg::ACTION_W-1:0] out_action_reg, out_action_next;

    // Memory ports.
    logic                         cache_we;
    logic [AW-1:0]                cache_waddr;
    logic [fee_pkg::DATA_W-1:0]   cache_wdata;
    logic [AW-1:0]                cache_raddr;
    logic [fee_pkg::DATA_W-1:0]   cache_rdata;

    logic                         seq_fwe;
    logic [FA_W-1:0]              seq_faddr;
    logic [fee_pkg::DATA_W-1:0]   seq_fwdata;
    logic                         flash_we;
    logic [FA_W-1:0]              flash_waddr;
    logic [fee_pkg::DATA_W-1:0]   flash_wdata;
    logic [FA_W-1:0]              flash_raddr;
    logic [fee_pkg::DATA_W-1:0]   flash_rdata;

    // Shared compare unit and address reduction.
    logic [fee_pkg::DATA_W-1:0]   cmp_a;
    fee_pkg::cmp_flags_t          flags;
    logic                         mod_start;
    logic                         mod_done;
    logic [AW-1:0]                mod_rem;
    logic                         in_ready;

    fee_addr_mod #(
        .BYTES_EMULATED(BYTES_EMULATED)
    ) u_addr_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .address (req.address),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    fee_byte_unit u_byte_unit (
        .a     (cmp_a),
        .b     (value_reg),
        .flags (flags)
    );

    fee_ram #(
        .WIDTH(fee_pkg::DATA_W),
        .DEPTH(BYTES_EMULATED)
    ) u_cache (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cache_waddr),
        .wdata (cache_wdata),
        .raddr (cache_raddr),
        .rdata (cache_rdata)
    );

    fee_ram #(
        .WIDTH(fee_pkg::DATA_W),
        .DEPTH(FLASH_DEPTH)
    ) u_flash (
        .clk   (clk),
        .we    (flash_we),
        .waddr (flash_waddr),
        .wdata (flash_wdata),
        .raddr (flash_raddr),
        .rdata (flash_rdata)
    );

    // The delayed erase write never meets a sequencer write, so a plain
    // priority mux is enough for the single flash write port.
    always_comb
    begin
        flash_we    = pw_valid_reg || seq_fwe;
        flash_waddr = pw_valid_reg ? pw_addr_reg : seq_faddr;
        if (pw_valid_reg)
        begin
            flash_wdata = pw_from_cache_reg ? cache_rdata : fee_pkg::ERASED_BYTE;
        end
        else
        begin
            flash_wdata = seq_fwdata;
        end
    end

    assign sw_last = (sw_copy_reg == LAST_COPY) && (sw_addr_reg == LAST_ADDR);

    always_comb
    begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        value_next         = value_reg;
        addr_next          = addr_reg;
        copy_next          = copy_reg;
        where_next         = where_reg;
        cur_next           = cur_reg;
        sw_addr_next       = sw_addr_reg;
        sw_copy_next       = sw_copy_reg;
        pw_valid_next      = 1'b0;
        pw_addr_next       = pw_addr_reg;
        pw_from_cache_next = pw_from_cache_reg;
        res_data_next      = res_data_reg;
        res_action_next    = res_action_reg;
        out_valid_next     = out_valid_reg && !rsp.ready;
        out_data_next      = out_data_reg;
        out_action_next    = out_action_reg;

        cache_we    = 1'b0;
        cache_waddr = addr_reg;
        cache_wdata = value_reg;
        cache_raddr = addr_reg;
        seq_fwe     = 1'b0;
        seq_faddr   = {where_reg, addr_reg};
        seq_fwdata  = cur_reg & value_reg;
        flash_raddr = {copy_reg, addr_reg};
        cmp_a       = flash_rdata;
        mod_start   = 1'b0;
        in_ready    = 1'b0;

        // The sweep walks every byte of copy zero first, then the other copies.
        if (state_reg == S_CLEAR || state_reg == S_ERASE)
        begin
            if (sw_addr_reg == LAST_ADDR)
            begin
                sw_addr_next = '0;
                sw_copy_next = sw_copy_reg + CW'(1);
            end
            else
            begin
                sw_addr_next = sw_addr_reg + AW'(1);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                seq_fwe     = 1'b1;
                seq_faddr   = {sw_copy_reg, sw_addr_reg};
                seq_fwdata  = fee_pkg::ERASED_BYTE;
                cache_we    = (sw_copy_reg == '0);
                cache_waddr = sw_addr_reg;
                cache_wdata = fee_pkg::ERASED_BYTE;
                if (sw_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid)
                begin
                    kind_next  = req.req_type;
                    value_next = req.write_value;
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    addr_next = mod_rem;
                    if (kind_reg == fee_pkg::REQ_WRITE)
                    begin
                        // The cache takes the new value at once; the search
                        // for the newest copy starts at the last copy.
                        cache_we    = 1'b1;
                        cache_waddr = mod_rem;
                        cache_wdata = value_reg;
                        copy_next   = LAST_COPY;
                        flash_raddr = {LAST_COPY, mod_rem};
                        state_next  = S_DN_CHK;
                    end
                    else
                    begin
                        cache_raddr = mod_rem;
                        state_next  = S_RD_WAIT;
                    end
                end
            end

            S_RD_WAIT:
            begin
                res_data_next   = cache_rdata;
                res_action_next = fee_pkg::ACT_READ;
                state_next      = S_DONE;
            end

            S_DN_CHK:
            begin
                if (!flags.a_erased)
                begin
                    cur_next   = flash_rdata;
                    where_next = copy_reg;
                    state_next = S_DECIDE;
                end
                else if (copy_reg == '0)
                begin
                    // No copy programmed yet: treat copy zero as the home.
                    cur_next   = fee_pkg::ERASED_BYTE;
                    where_next = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    copy_next   = copy_reg - CW'(1);
                    flash_raddr = {copy_reg - CW'(1), addr_reg};
                end
            end

            S_DECIDE:
            begin
                cmp_a         = cur_reg;
                res_data_next = '0;
                if (flags.equal)
                begin
                    res_action_next = fee_pkg::ACT_UNCHANGED;
                    state_next      = S_DONE;
                end
                else if (flags.clear_only)
                begin
                    seq_fwe         = 1'b1;
                    res_action_next = fee_pkg::ACT_IN_PLACE;
                    state_next      = S_DONE;
                end
                else if (!flags.b_erased)
                begin
                    copy_next   = '0;
                    flash_raddr = {CW'(0), addr_reg};
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    sw_addr_next = '0;
                    sw_copy_next = '0;
                    state_next   = S_ERASE;
                end
            end

            S_UP_CHK:
            begin
                if (flags.a_erased)
                begin
                    seq_fwe         = 1'b1;
                    seq_faddr       = {copy_reg, addr_reg};
                    seq_fwdata      = value_reg;
                    res_action_next = fee_pkg::ACT_NEW_COPY;
                    state_next      = S_DONE;
                end
                else if (copy_reg == LAST_COPY)
                begin
                    sw_addr_next = '0;
                    sw_copy_next = '0;
                    state_next   = S_ERASE;
                end
                else
                begin
                    copy_next   = copy_reg + CW'(1);
                    flash_raddr = {copy_reg + CW'(1), addr_reg};
                end
            end

            S_ERASE:
            begin
                cache_raddr        = sw_addr_reg;
                pw_valid_next      = 1'b1;
                pw_addr_next       = {sw_copy_reg, sw_addr_reg};
                pw_from_cache_next = (sw_copy_reg == '0);
                if (sw_last)
                begin
                    res_data_next   = '0;
                    res_action_next = fee_pkg::ACT_ERASED;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_action_next = res_action_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sw_addr_reg   <= '0;
            sw_copy_reg   <= '0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sw_addr_reg   <= sw_addr_next;
            sw_copy_reg   <= sw_copy_next;
            pw_valid_reg  <= pw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        value_reg         <= value_next;
        addr_reg          <= addr_next;
        copy_reg          <= copy_next;
        where_reg         <= where_next;
        cur_reg           <= cur_next;
        pw_addr_reg       <= pw_addr_next;
        pw_from_cache_reg <= pw_from_cache_next;
        res_data_reg      <= res_data_next;
        res_action_reg    <= res_action_next;
        out_data_reg      <= out_data_next;
        out_action_reg    <= out_action_next;
    end

    assign req.ready     = in_ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.action    = out_action_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second beat accepted while an item is in work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the completion step");

    a_flash_port: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid_reg |-> !seq_fwe)
        else $error("erase write collides with a sequencer flash write");

    a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_CHK || state_reg == S_UP_CHK) |-> (copy_reg <= LAST_COPY))
        else $error("copy index beyond the last copy");

endmodule
